FILE: rtl/dhf_pkg.sv
package dhf_pkg;

    localparam int PIX_W  = 8;
    localparam int ROW_W  = 16;
    localparam int NORM_IN_W  = 34;
    localparam int NORM_OUT_W = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESH   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_THRESH = 4'd3;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [7:0]  DARK_RESET   = 8'd10;
    localparam logic [8:0]  SMOOTH_RESET = 9'd150;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       replaced;
        logic       frame_last;
    } pixel_out_t;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHECK  = 9'b000000010,
        ST_READ   = 9'b000000100,
        ST_FLUSH  = 9'b000001000,
        ST_DIV    = 9'b000010000,
        ST_SQ     = 9'b000100000,
        ST_SQRT_A = 9'b001000000,
        ST_SQRT_P = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

endpackage

FILE: rtl/dhf_divider.sv
module dhf_divider #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[NUM_W-1]};
        if (start && !busy_reg) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = DEN_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial[DEN_W-1:0];
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

FILE: rtl/dhf_isqrt.sv
module dhf_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [dhf_pkg::NORM_IN_W-1:0]  value,
    output logic                           done,
    output logic [dhf_pkg::NORM_OUT_W-1:0] root
);
    localparam int IW = dhf_pkg::NORM_IN_W;
    localparam int OW = dhf_pkg::NORM_OUT_W;
    localparam int RW = OW + 2;
    localparam int CW = $clog2(OW + 1);

    logic [IW-1:0] v_reg, v_next;
    logic [OW-1:0] q_reg, q_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;

    always_comb begin
        v_next    = v_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_t     = {rem_reg, v_reg[IW-1:IW-2]};
        trial     = (RW+2)'({q_reg, 2'b01});
        if (start && !busy_reg) begin
            v_next    = value;
            q_next    = '0;
            rem_next  = '0;
            cnt_next  = CW'(OW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_t >= trial) begin
                rem_next = RW'(rem_t - trial);
                q_next   = {q_reg[OW-2:0], 1'b1};
            end else begin
                rem_next = RW'(rem_t);
                q_next   = {q_reg[OW-2:0], 1'b0};
            end
            v_next   = {v_reg[IW-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        v_reg   <= v_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign root = q_reg;
endmodule

FILE: rtl/dark_hole_fill_window_filter.sv
// Dark-hole fill filter over a square window of radius RADIUS. Pixels go into a line
// store of 2*RADIUS+2 rows; each result is built by reading the whole window from that
// store one entry per cycle, dividing the three neighbour sums on a shared bit-serial
// divider and taking both norms on a shared bit-serial square root. An item whose window
// is not yet complete only passes the check state; otherwise no new pixel is taken until
// its result is done, as the single read port of the line store, the divider and the
// square root serve one item at a time. A finished pixel waits in the output register
// while the next item is taken; while it is still untaken, the next result stalls until
// it leaves. Writing image_width or image_height starts a new frame.
module dark_hole_fill_window_filter #(
    parameter int MAX_WIDTH = 2048,
    parameter int RADIUS    = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dhf_pkg::pixel_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dhf_pkg::pixel_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dhf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dhf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int SLOTS = 2 * RADIUS + 2;
    localparam int WS    = 2 * RADIUS + 1;
    localparam int TAPS  = WS * WS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SW    = $clog2(SLOTS);
    localparam int DW    = $clog2(WS);
    localparam int DEPTH = SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(TAPS);
    localparam int SUMW  = 8 + CNTW;
    localparam int NUMW  = SUMW + 8;
    localparam int RW    = dhf_pkg::ROW_W;
    localparam int NIW   = dhf_pkg::NORM_IN_W;
    localparam int NOW   = dhf_pkg::NORM_OUT_W;

    dhf_pkg::state_t state_reg, state_next;

    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  dark_reg;
    logic [8:0]  smooth_reg;

    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [SW-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic          frame_in_reg, frame_in_next;

    logic [DW-1:0] dy_reg, dy_next, dx_reg, dx_next;
    logic          rd_v_reg, rd_v_next, rd_in_reg, rd_in_next, rd_ctr_reg, rd_ctr_next;
    logic [23:0]   rdata_reg;
    logic [23:0]   px_reg, px_next;
    logic [SUMW-1:0] sum_reg [3];
    logic [SUMW-1:0] sum_next [3];
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [15:0]   avg_reg [3];
    logic [15:0]   avg_next [3];
    logic [1:0]    k_reg, k_next;
    logic          wait_reg, wait_next;
    logic [NIW-1:0] sa_reg, sa_next;
    logic [17:0]   sp_reg, sp_next;
    logic          dark_f_reg, dark_f_next, below_reg, below_next;
    logic [NOW-1:0] na_reg, na_next;
    logic          repl_reg, repl_next;

    logic                m_valid_reg, m_valid_next;
    dhf_pkg::pixel_out_t m_data_reg, m_data_next;

    logic [23:0] mem [DEPTH];
    logic          mem_we, mem_re;
    logic [AW-1:0] waddr, raddr;

    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [CW:0]   in_col_inc, out_col_inc;
    logic [RW:0]   in_row_inc, out_row_inc;
    logic [RW:0]   lr, rsum;
    logic [CW:0]   lc, csum;
    logic          out_rdy, tap_in;
    logic [SW+1:0] ssum;
    logic [SW-1:0] rslot;
    logic [CW-1:0] ncol;
    logic [7:0]    pk;
    logic [SUMW-1:0] sk;
    logic          accept, centre_tap, last_tap;

    logic            div_start, div_done;
    logic [NUMW-1:0] div_q;
    logic            sq_start, sq_done;
    logic [NIW-1:0]  sq_val;
    logic [NOW-1:0]  sq_root;
    logic [NOW-1:0]  smooth_fx;

    dhf_divider #(.NUM_W(NUMW), .DEN_W(CNTW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_reg[k_reg], 8'b0}),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    dhf_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   (sq_val),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_comb begin
        if (width_reg == 12'd0) begin
            eff_w = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(width_reg);
        end
        eff_h = (height_reg == 16'd0) ? RW'(1) : height_reg;
    end

    always_comb begin
        case (k_reg)
            2'd0:    pk = px_reg[23:16];
            2'd1:    pk = px_reg[15:8];
            default: pk = px_reg[7:0];
        endcase
        case (k_reg)
            2'd0:    sk = sum_reg[0];
            2'd1:    sk = sum_reg[1];
            default: sk = sum_reg[2];
        endcase
    end

    assign accept     = s_valid && s_ready;
    assign in_col_inc = {1'b0, in_col_reg} + 1'b1;
    assign in_row_inc = {1'b0, in_row_reg} + 1'b1;
    assign out_col_inc = {1'b0, out_col_reg} + 1'b1;
    assign out_row_inc = {1'b0, out_row_reg} + 1'b1;
    assign mem_we = accept && !s_data.mode && !frame_in_reg;
    assign waddr  = AW'(32'(in_slot_reg) * MAX_WIDTH + 32'(in_col_reg));
    assign centre_tap = (dy_reg == DW'(RADIUS)) && (dx_reg == DW'(RADIUS));
    assign last_tap   = (dy_reg == DW'(WS - 1)) && (dx_reg == DW'(WS - 1));
    assign smooth_fx  = {smooth_reg, 8'b0};

    always_comb begin
        lr = {1'b0, out_row_reg} + (RW+1)'(RADIUS);
        if (lr > {1'b0, eff_h} - 1'b1) begin
            lr = {1'b0, eff_h} - 1'b1;
        end
        lc = {1'b0, out_col_reg} + (CW+1)'(RADIUS);
        if ((CW+1)'(lc) > (CW+1)'(eff_w - 1'b1)) begin
            lc = (CW+1)'(eff_w - 1'b1);
        end
        out_rdy = frame_in_reg || (lr < {1'b0, in_row_reg}) ||
                  ((lr == {1'b0, in_row_reg}) && (lc < {1'b0, in_col_reg}));
        rsum = {1'b0, out_row_reg} + (RW+1)'(dy_reg);
        csum = {1'b0, out_col_reg} + (CW+1)'(dx_reg);
        tap_in = (rsum >= (RW+1)'(RADIUS)) &&
                 ((rsum - (RW+1)'(RADIUS)) < {1'b0, eff_h}) &&
                 (csum >= (CW+1)'(RADIUS)) &&
                 ((WW+1)'(csum - (CW+1)'(RADIUS)) < (WW+1)'(eff_w));
        ncol = CW'(csum - (CW+1)'(RADIUS));
        ssum = (SW+2)'(out_slot_reg) + (SW+2)'(dy_reg) + (SW+2)'(SLOTS - RADIUS);
        if (ssum >= (SW+2)'(SLOTS)) ssum = ssum - (SW+2)'(SLOTS);
        if (ssum >= (SW+2)'(SLOTS)) ssum = ssum - (SW+2)'(SLOTS);
        rslot = SW'(ssum);
        raddr = tap_in ? AW'(32'(rslot) * MAX_WIDTH + 32'(ncol)) : '0;
    end

    assign mem_re = (state_reg == dhf_pkg::ST_READ);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= {s_data.red_in, s_data.green_in, s_data.blue_in};
        end
        if (mem_re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb begin
        state_next    = state_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        frame_in_next = frame_in_reg;
        dy_next       = dy_reg;
        dx_next       = dx_reg;
        rd_v_next     = 1'b0;
        rd_in_next    = tap_in;
        rd_ctr_next   = centre_tap;
        px_next       = px_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        avg_next      = avg_reg;
        k_next        = k_reg;
        wait_next     = wait_reg;
        sa_next       = sa_reg;
        sp_next       = sp_reg;
        dark_f_next   = dark_f_reg;
        below_next    = below_reg;
        na_next       = na_reg;
        repl_next     = repl_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        sq_start      = 1'b0;
        sq_val        = sa_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (rd_v_reg) begin
            if (rd_ctr_reg) begin
                px_next = rdata_reg;
            end else if (rd_in_reg) begin
                sum_next[0] = sum_reg[0] + SUMW'(rdata_reg[23:16]);
                sum_next[1] = sum_reg[1] + SUMW'(rdata_reg[15:8]);
                sum_next[2] = sum_reg[2] + SUMW'(rdata_reg[7:0]);
                cnt_next    = cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            dhf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (mem_we) begin
                        if (in_col_inc >= (CW+1)'(eff_w)) begin
                            in_col_next = '0;
                            if (in_row_inc >= {1'b0, eff_h}) begin
                                in_row_next   = '0;
                                in_slot_next  = '0;
                                frame_in_next = 1'b1;
                            end else begin
                                in_row_next  = RW'(in_row_inc);
                                in_slot_next = (in_slot_reg == SW'(SLOTS - 1)) ? '0 :
                                               in_slot_reg + 1'b1;
                            end
                        end else begin
                            in_col_next = CW'(in_col_inc);
                        end
                    end
                    state_next = dhf_pkg::ST_CHECK;
                end
            end
            dhf_pkg::ST_CHECK: begin
                if (out_rdy) begin
                    dy_next  = '0;
                    dx_next  = '0;
                    cnt_next = '0;
                    sum_next[0] = '0;
                    sum_next[1] = '0;
                    sum_next[2] = '0;
                    state_next = dhf_pkg::ST_READ;
                end else begin
                    state_next = dhf_pkg::ST_IDLE;
                end
            end
            dhf_pkg::ST_READ: begin
                rd_v_next = 1'b1;
                if (dx_reg == DW'(WS - 1)) begin
                    dx_next = '0;
                    dy_next = dy_reg + 1'b1;
                end else begin
                    dx_next = dx_reg + 1'b1;
                end
                if (last_tap) begin
                    state_next = dhf_pkg::ST_FLUSH;
                end
            end
            dhf_pkg::ST_FLUSH: begin
                k_next     = '0;
                wait_next  = 1'b0;
                state_next = dhf_pkg::ST_DIV;
            end
            dhf_pkg::ST_DIV: begin
                if (cnt_reg == '0) begin
                    repl_next  = 1'b0;
                    state_next = dhf_pkg::ST_DONE;
                end else if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    avg_next[k_reg] = div_q[15:0];
                    wait_next = 1'b0;
                    if (k_reg == 2'd2) begin
                        k_next      = '0;
                        sa_next     = '0;
                        sp_next     = '0;
                        dark_f_next = 1'b1;
                        below_next  = 1'b1;
                        state_next  = dhf_pkg::ST_SQ;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            dhf_pkg::ST_SQ: begin
                sa_next = sa_reg + NIW'(avg_reg[k_reg] * avg_reg[k_reg]);
                sp_next = sp_reg + 18'(pk * pk);
                if (pk >= dark_reg) dark_f_next = 1'b0;
                if ((SUMW'(pk) * SUMW'(cnt_reg)) >= sk) below_next = 1'b0;
                if (k_reg == 2'd2) begin
                    k_next     = '0;
                    wait_next  = 1'b0;
                    state_next = dhf_pkg::ST_SQRT_A;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            dhf_pkg::ST_SQRT_A: begin
                sq_val = sa_reg;
                if (!wait_reg) begin
                    sq_start  = 1'b1;
                    wait_next = 1'b1;
                end else if (sq_done) begin
                    na_next    = sq_root;
                    wait_next  = 1'b0;
                    state_next = dhf_pkg::ST_SQRT_P;
                end
            end
            dhf_pkg::ST_SQRT_P: begin
                sq_val = {sp_reg, 16'b0};
                if (!wait_reg) begin
                    sq_start  = 1'b1;
                    wait_next = 1'b1;
                end else if (sq_done) begin
                    wait_next  = 1'b0;
                    repl_next  = dark_f_reg ||
                                 (below_reg && (na_reg > sq_root) &&
                                  ((na_reg - sq_root) > smooth_fx));
                    state_next = dhf_pkg::ST_DONE;
                end
            end
            dhf_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.red_out   = repl_reg ? avg_reg[0][15:8] : px_reg[23:16];
                    m_data_next.green_out = repl_reg ? avg_reg[1][15:8] : px_reg[15:8];
                    m_data_next.blue_out  = repl_reg ? avg_reg[2][15:8] : px_reg[7:0];
                    m_data_next.replaced  = repl_reg;
                    m_data_next.frame_last = (out_row_reg == eff_h - 1'b1) &&
                                             ((WW)'(out_col_reg) == eff_w - 1'b1);
                    if (out_col_inc >= (CW+1)'(eff_w)) begin
                        out_col_next = '0;
                        if (out_row_inc >= {1'b0, eff_h}) begin
                            out_row_next  = '0;
                            out_slot_next = '0;
                            frame_in_next = 1'b0;
                        end else begin
                            out_row_next  = RW'(out_row_inc);
                            out_slot_next = (out_slot_reg == SW'(SLOTS - 1)) ? '0 :
                                            out_slot_reg + 1'b1;
                        end
                    end else begin
                        out_col_next = CW'(out_col_inc);
                    end
                    state_next = dhf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dhf_pkg::ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready &&
            (cfg_index == dhf_pkg::REG_IMAGE_WIDTH ||
             cfg_index == dhf_pkg::REG_IMAGE_HEIGHT)) begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            frame_in_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dhf_pkg::ST_IDLE;
            width_reg    <= dhf_pkg::WIDTH_RESET;
            height_reg   <= dhf_pkg::HEIGHT_RESET;
            dark_reg     <= dhf_pkg::DARK_RESET;
            smooth_reg   <= dhf_pkg::SMOOTH_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            frame_in_reg <= 1'b0;
            rd_v_reg     <= 1'b0;
            wait_reg     <= 1'b0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            frame_in_reg <= frame_in_next;
            rd_v_reg     <= rd_v_next;
            wait_reg     <= wait_next;
            k_reg        <= k_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dhf_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data[11:0];
                    dhf_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                    dhf_pkg::REG_DARK_THRESH:   dark_reg   <= cfg_data[7:0];
                    dhf_pkg::REG_SMOOTH_THRESH: smooth_reg <= cfg_data[8:0];
                    default: ;
                endcase
            end
        end
        dy_reg     <= dy_next;
        dx_reg     <= dx_next;
        rd_in_reg  <= rd_in_next;
        rd_ctr_reg <= rd_ctr_next;
        px_reg     <= px_next;
        sum_reg    <= sum_next;
        cnt_reg    <= cnt_next;
        avg_reg    <= avg_next;
        sa_reg     <= sa_next;
        sp_reg     <= sp_next;
        dark_f_reg <= dark_f_next;
        below_reg  <= below_next;
        na_reg     <= na_next;
        repl_reg   <= repl_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = (state_reg == dhf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
endmodule

FILE: rtl/dhf_checker.sv
module dhf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dhf_pkg::pixel_out_t m_data
);
    // output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one item at a time: input closes after a request
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after a request");

    // a result needs at least the window check after a request
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared one cycle after a request");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");
endmodule

bind dark_hole_fill_window_filter dhf_checker u_dhf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
